>>> hdl/ccr_pkg.sv
package ccr_pkg;

  typedef enum logic [1:0] {
    KIND_ROW_PTR = 2'd0,
    KIND_NONZERO = 2'd1,
    KIND_VECTOR  = 2'd2,
    KIND_COMPUTE = 2'd3
  } kind_e;

  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_SAT      = 2'd1;
  localparam logic [1:0] STATUS_BAD_ROW  = 2'd2;

  // rounded Q.16 term of a Q32.32 product, half up
  function automatic logic signed [47:0] round_q16(input logic signed [63:0] p);
    logic signed [63:0] s;
    begin
      s = p + 64'sd32768;
      return s[63:16];
    end
  endfunction

endpackage

>>> hdl/complex_csr_residual_core.sv
// Residual engine for a sparse complex system in compressed sparse row form.
// Load requests (row pointer, nonzero, vector entry) write on accept and keep
// the core idle. A compute request strobes its result: two pointer reads,
// then per nonzero two memory reads and four products on the shared 32x32
// multiplier, each accumulated (a row at or beyond row_count goes straight
// to the strobe); a new request is taken in the strobe cycle, no stall.
// Reset (rst_ni low, asynchronous) clears control and sets row_count to 1024.
module complex_csr_residual_core #(
  parameter int unsigned MAX_ROWS     = 1024,
  parameter int unsigned MAX_NONZEROS = 8192
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic               cfg_we_i,
  input  logic [10:0]        cfg_wdata_i,
  input  logic [1:0]         kind_i,
  input  logic [13:0]        index_i,
  input  logic [13:0]        row_start_i,
  input  logic [9:0]         column_i,
  input  logic signed [31:0] weight_w_i,
  input  logic signed [31:0] weight_t_i,
  input  logic signed [31:0] unknown_re_i,
  input  logic signed [31:0] unknown_im_i,
  input  logic signed [31:0] rhs_re_i,
  input  logic signed [31:0] rhs_im_i,
  output logic               done_o,
  output logic [9:0]         row_o,
  output logic signed [31:0] residual_first_o,
  output logic signed [31:0] residual_second_o,
  output logic [1:0]         status_o
);

  localparam int unsigned RowAw = $clog2(MAX_ROWS);
  localparam int unsigned PtrAw = $clog2(MAX_ROWS + 1);
  localparam int unsigned NzAw  = $clog2(MAX_NONZEROS);
  localparam int unsigned PtrW  = 14;
  localparam logic signed [63:0] AccLim = 64'sh4000_0000_0000_0000;

  // sequencer states
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_PTR0  = 4'd1;  // row start on the read port
  localparam logic [3:0] S_PTR1  = 4'd2;  // next row start on the read port
  localparam logic [3:0] S_RANGE = 4'd3;  // both pointers known
  localparam logic [3:0] S_NZRD  = 4'd4;  // nonzero read in flight
  localparam logic [3:0] S_VRD   = 4'd5;  // vector read in flight
  localparam logic [3:0] S_M0    = 4'd6;  // four products, one a cycle
  localparam logic [3:0] S_M1    = 4'd7;
  localparam logic [3:0] S_M2    = 4'd8;
  localparam logic [3:0] S_M3    = 4'd9;
  localparam logic [3:0] S_M4    = 4'd10; // last product accumulate
  localparam logic [3:0] S_RHS   = 4'd11; // rhs read in flight
  localparam logic [3:0] S_FIN   = 4'd12;
  localparam logic [3:0] S_OUT   = 4'd13;

  logic [3:0] state_q, state_d;
  logic [10:0] row_count_q;
  logic [13:0] idx_q;
  logic [PtrW-1:0] ptr_q, end_q;
  logic signed [63:0] s1_q, s2_q;
  logic sat_q;
  logic signed [31:0] w_q, t_q, ure_q, uim_q;
  logic signed [63:0] prod_q;
  logic [1:0] prod_sel_q;   // which accumulator/sign the product feeds
  logic prod_vld_q;
  logic col_ok_q;
  logic done_q;
  logic [1:0] status_q;
  logic signed [31:0] r1_q, r2_q;

  wire accept = start && !busy;
  wire [10:0] limit = (row_count_q > 11'(MAX_ROWS)) ? 11'(MAX_ROWS) : row_count_q;

  // ---------------- memories ----------------
  logic ptr_we, nz_we, vec_we;
  logic [PtrAw-1:0] ptr_ra;
  logic [PtrW-1:0] ptr_rd;
  logic [NzAw-1:0] nz_ra;
  logic [9:0] col_rd;
  logic signed [31:0] w_rd, t_rd;
  logic [RowAw-1:0] vec_ra;
  logic signed [31:0] ure_rd, uim_rd, bre_rd, bim_rd;

  assign ptr_we = accept && kind_i == ccr_pkg::KIND_ROW_PTR && index_i <= 14'(MAX_ROWS);
  assign nz_we  = accept && kind_i == ccr_pkg::KIND_NONZERO && index_i < 14'(MAX_NONZEROS);
  assign vec_we = accept && kind_i == ccr_pkg::KIND_VECTOR  && index_i < 14'(MAX_ROWS);

  ccr_ram #(.Width(PtrW), .Depth(MAX_ROWS + 1)) u_ptr (
    .clk_i, .we_i(ptr_we), .waddr_i(index_i[PtrAw-1:0]), .wdata_i(row_start_i),
    .raddr_i(ptr_ra), .rdata_o(ptr_rd));
  ccr_ram #(.Width(74), .Depth(MAX_NONZEROS)) u_nz (
    .clk_i, .we_i(nz_we), .waddr_i(index_i[NzAw-1:0]),
    .wdata_i({column_i, weight_w_i, weight_t_i}),
    .raddr_i(nz_ra), .rdata_o({col_rd, w_rd, t_rd}));
  ccr_ram #(.Width(64), .Depth(MAX_ROWS)) u_u (
    .clk_i, .we_i(vec_we), .waddr_i(index_i[RowAw-1:0]),
    .wdata_i({unknown_re_i, unknown_im_i}),
    .raddr_i(vec_ra), .rdata_o({ure_rd, uim_rd}));
  ccr_ram #(.Width(64), .Depth(MAX_ROWS)) u_b (
    .clk_i, .we_i(vec_we), .waddr_i(index_i[RowAw-1:0]),
    .wdata_i({rhs_re_i, rhs_im_i}),
    .raddr_i(idx_q[RowAw-1:0]), .rdata_o({bre_rd, bim_rd}));

  // read addresses
  always_comb begin
    ptr_ra = (state_q == S_PTR0) ? PtrAw'(idx_q + 14'd1) : idx_q[PtrAw-1:0];
    if (state_q == S_IDLE) ptr_ra = index_i[PtrAw-1:0];
    nz_ra = ptr_q[NzAw-1:0];
    vec_ra = col_rd[RowAw-1:0];
  end

  // ---------------- shared multiplier ----------------
  logic signed [31:0] ma, mb;
  always_comb begin
    case (state_q)
      S_M0:    begin ma = t_q; mb = ure_q; end
      S_M1:    begin ma = w_q; mb = uim_q; end
      S_M2:    begin ma = w_q; mb = ure_q; end
      default: begin ma = t_q; mb = uim_q; end
    endcase
  end

  // saturating accumulate of the registered product
  logic signed [47:0] term;
  logic signed [64:0] sum;
  logic signed [63:0] acc_sel, acc_new;
  logic acc_sat;
  always_comb begin
    term = ccr_pkg::round_q16(prod_q);
    acc_sel = prod_sel_q[1] ? s2_q : s1_q;
    if (prod_sel_q == 2'd1) sum = 65'(acc_sel) - 65'(term);
    else                    sum = 65'(acc_sel) + 65'(term);
    acc_sat = 1'b0;
    acc_new = sum[63:0];
    if (sum > 65'(AccLim)) begin
      acc_new = AccLim; acc_sat = 1'b1;
    end else if (sum < -65'(AccLim)) begin
      acc_new = -AccLim; acc_sat = 1'b1;
    end
  end

  // final differences
  logic signed [64:0] d1, d2;
  logic signed [31:0] r1_d, r2_d;
  logic f_sat;
  always_comb begin
    d1 = 65'(bim_rd) - 65'(s1_q);
    d2 = 65'(bre_rd) - 65'(s2_q);
    f_sat = 1'b0;
    r1_d = d1[31:0];
    r2_d = d2[31:0];
    if (d1 > 65'sd2147483647) begin r1_d = 32'sh7fffffff; f_sat = 1'b1; end
    else if (d1 < -65'sd2147483648) begin r1_d = 32'sh80000000; f_sat = 1'b1; end
    if (d2 > 65'sd2147483647) begin r2_d = 32'sh7fffffff; f_sat = 1'b1; end
    else if (d2 < -65'sd2147483648) begin r2_d = 32'sh80000000; f_sat = 1'b1; end
  end

  wire [PtrW-1:0] end_clip = (ptr_rd > PtrW'(MAX_NONZEROS)) ? PtrW'(MAX_NONZEROS) : ptr_rd;

  // ---------------- sequencer ----------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept && kind_i == ccr_pkg::KIND_COMPUTE) begin
          state_d = (index_i >= 14'(limit)) ? S_OUT : S_PTR0;
        end
      end
      S_PTR0:  state_d = S_PTR1;
      S_PTR1:  state_d = S_RANGE;
      S_RANGE: state_d = (ptr_q < end_q) ? S_NZRD : S_RHS;
      S_NZRD:  state_d = S_VRD;
      S_VRD:   state_d = S_M0;
      S_M0:    state_d = S_M1;
      S_M1:    state_d = S_M2;
      S_M2:    state_d = S_M3;
      S_M3:    state_d = S_M4;
      S_M4:    state_d = (ptr_q < end_q) ? S_NZRD : S_RHS;
      S_RHS:   state_d = S_FIN;
      S_FIN:   state_d = S_OUT;
      S_OUT:   state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      row_count_q <= 11'd1024;
      done_q      <= 1'b0;
      prod_vld_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) row_count_q <= cfg_wdata_i;
      done_q <= (state_q == S_OUT);
      prod_vld_q <= col_ok_q && (state_q == S_M0 || state_q == S_M1 ||
                                 state_q == S_M2 || state_q == S_M3);
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    prod_q     <= 64'(ma) * 64'(mb);
    prod_sel_q <= (state_q == S_M0) ? 2'd0 : (state_q == S_M1) ? 2'd1 :
                  (state_q == S_M2) ? 2'd2 : 2'd3;
    if (prod_vld_q) begin
      if (prod_sel_q[1]) s2_q <= acc_new;
      else               s1_q <= acc_new;
      if (acc_sat) sat_q <= 1'b1;
    end
    case (state_q)
      S_IDLE: begin
        idx_q <= index_i;
        s1_q <= '0; s2_q <= '0; sat_q <= 1'b0;
        status_q <= ccr_pkg::STATUS_BAD_ROW;
        r1_q <= '0; r2_q <= '0;
      end
      S_PTR0:  ptr_q <= ptr_rd;
      S_PTR1:  end_q <= end_clip;
      S_VRD: begin
        // hold the nonzero and its vector entry, advance the slot
        w_q <= w_rd; t_q <= t_rd;
        ure_q <= ure_rd; uim_q <= uim_rd;
        col_ok_q <= col_rd < 10'(MAX_ROWS - 1) || col_rd == 10'(MAX_ROWS - 1);
        ptr_q <= ptr_q + 1'b1;
      end
      S_FIN: begin
        r1_q <= r1_d; r2_q <= r2_d;
        status_q <= (sat_q || f_sat) ? ccr_pkg::STATUS_SAT : ccr_pkg::STATUS_OK;
      end
      default: ;
    endcase
  end

  assign busy              = (state_q != S_IDLE);
  assign done_o            = done_q;
  assign row_o             = idx_q[9:0];
  assign residual_first_o  = r1_q;
  assign residual_second_o = r2_q;
  assign status_o          = status_q;

`ifndef SYNTH
  a_done_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("result strobe longer than one cycle");
  a_busy_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(busy)) else $error("result without request");
  a_bad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && status_o == ccr_pkg::STATUS_BAD_ROW |-> residual_first_o == 0 &&
    residual_second_o == 0) else $error("bad row carries data");
`endif

endmodule

>>> hdl/ccr_ram.sv
module ccr_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule
